### hdl/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
package qrs_pkg;

    localparam int CoefW  = 32;            // coefficient and root width
    localparam int FracW  = 16;            // fraction bits
    localparam int DiscW  = 2 * CoefW;     // clipped discriminant width
    localparam int RootW  = DiscW / 2;     // square root width
    localparam int NumW   = CoefW + 2;     // root numerator / denominator width
    localparam int QuotW  = NumW + FracW;  // dividend and quotient width
    localparam int SqSteps  = RootW;       // square root cells
    localparam int DivSteps = QuotW;       // divider cells

    typedef enum logic [2:0] {
        OUT_TWO      = 3'd0,
        OUT_DOUBLE   = 3'd1,
        OUT_LINEAR   = 3'd2,
        OUT_NONE     = 3'd3,
        OUT_INFINITE = 3'd4
    } t_outcome;

    typedef enum logic {
        CFG_COEF_TOL = 1'b0,
        CFG_DISC_TOL = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [CoefW-1:0] coef_a;
        logic signed [CoefW-1:0] coef_b;
        logic signed [CoefW-1:0] coef_c;
    } t_coefs;

    typedef struct packed {
        t_outcome                outcome;
        logic signed [CoefW-1:0] root_first;
        logic signed [CoefW-1:0] root_second;
        logic                    saturated;
    } t_result;

    // travels alongside the square root cells
    typedef struct packed {
        logic                    valid;
        t_outcome                outcome;
        logic                    sat;
        logic signed [CoefW-1:0] a;
        logic signed [CoefW-1:0] b;
        logic signed [CoefW-1:0] c;
    } t_sq_meta;

    // travels alongside the divider cells
    typedef struct packed {
        logic     valid;
        t_outcome outcome;
        logic     sat;
        logic     use1;
        logic     use2;
        logic     neg1;
        logic     neg2;
    } t_div_meta;

endpackage

### hdl/qrs_sqrt_cell.sv
// One digit step of the integer square root: two radicand bits in, one root bit out.
module qrs_sqrt_cell (
    input  logic                            i_clk,
    input  logic [qrs_pkg::DiscW-1:0]       i_rad,
    input  logic [qrs_pkg::RootW:0]         i_rem,
    input  logic [qrs_pkg::RootW-1:0]       i_root,
    output logic [qrs_pkg::DiscW-1:0]       o_rad,
    output logic [qrs_pkg::RootW:0]         o_rem,
    output logic [qrs_pkg::RootW-1:0]       o_root
);
    logic [qrs_pkg::RootW+2:0] w_try;
    logic [qrs_pkg::RootW+2:0] w_trial;
    logic                      w_fit;

    assign w_try   = {i_rem, i_rad[qrs_pkg::DiscW-1 -: 2]};
    assign w_trial = {1'b0, i_root, 2'b01};
    assign w_fit   = (w_try >= w_trial);

    always_ff @(posedge i_clk) begin
        o_rad  <= {i_rad[qrs_pkg::DiscW-3:0], 2'b00};
        o_rem  <= w_fit ? (qrs_pkg::RootW+1)'(w_try - w_trial) : w_try[qrs_pkg::RootW:0];
        o_root <= {i_root[qrs_pkg::RootW-2:0], w_fit};
    end
endmodule

### hdl/qrs_div_cell.sv
// One restoring step of the unsigned root divider: one quotient bit per cell.
module qrs_div_cell (
    input  logic                        i_clk,
    input  logic [qrs_pkg::QuotW-1:0]   i_num,
    input  logic [qrs_pkg::NumW-1:0]    i_den,
    input  logic [qrs_pkg::NumW-1:0]    i_rem,
    input  logic [qrs_pkg::QuotW-1:0]   i_quo,
    output logic [qrs_pkg::QuotW-1:0]   o_num,
    output logic [qrs_pkg::NumW-1:0]    o_den,
    output logic [qrs_pkg::NumW-1:0]    o_rem,
    output logic [qrs_pkg::QuotW-1:0]   o_quo
);
    logic [qrs_pkg::NumW:0] w_try;
    logic [qrs_pkg::NumW:0] w_diff;
    logic                   w_fit;

    assign w_try  = {i_rem, i_num[qrs_pkg::QuotW-1]};
    assign w_diff = w_try - {1'b0, i_den};
    assign w_fit  = (w_try >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        o_num <= {i_num[qrs_pkg::QuotW-2:0], 1'b0};
        o_den <= i_den;
        o_rem <= w_fit ? w_diff[qrs_pkg::NumW-1:0] : w_try[qrs_pkg::NumW-1:0];
        o_quo <= {i_quo[qrs_pkg::QuotW-2:0], w_fit};
    end
endmodule

### hdl/quadratic_root_solver_top.sv
// Top level of the quadratic root solver: products, discriminant, root and divider cell rows.
// A coefficient set is taken in every cycle (busy stays low) and its result strobes out
// after the product register, the discriminant register, 32 square root cells,
// 50 divider cells (one quotient bit each) and one output register. The pipeline
// length is set by the divider row. Results cannot be held off by the receiver; each is
// shown on o_res for the single cycle that o_valid is high.
module quadratic_root_solver_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  qrs_pkg::t_coefs       i_coef,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [31:0]           i_cfg_data,
    output logic                  o_valid,
    output qrs_pkg::t_result      o_res
);
    localparam int CW = qrs_pkg::CoefW;
    localparam int DW = qrs_pkg::DiscW;
    localparam int RW = qrs_pkg::RootW;
    localparam int NW = qrs_pkg::NumW;
    localparam int QW = qrs_pkg::QuotW;
    localparam int FW = qrs_pkg::FracW;

    logic [15:0] r_coef_tol;
    logic [31:0] r_disc_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_tol <= '0;
            r_disc_tol <= '0;
        end else if (i_cfg_we) begin
            unique case (qrs_pkg::t_cfg_idx'(i_cfg_idx))
                qrs_pkg::CFG_COEF_TOL: r_coef_tol <= i_cfg_data[15:0];
                qrs_pkg::CFG_DISC_TOL: r_disc_tol <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---- stage 1: products and the linear decision
    logic                 w_acc;
    logic [CW-1:0]        w_mag_a, w_mag_b, w_mag_c;
    logic                 w_lin;
    qrs_pkg::t_outcome    w_lin_out;

    assign w_acc   = start && !busy;
    assign w_mag_a = i_coef.coef_a[CW-1] ? CW'(-i_coef.coef_a) : i_coef.coef_a;
    assign w_mag_b = i_coef.coef_b[CW-1] ? CW'(-i_coef.coef_b) : i_coef.coef_b;
    assign w_mag_c = i_coef.coef_c[CW-1] ? CW'(-i_coef.coef_c) : i_coef.coef_c;
    assign w_lin   = (w_mag_a <= CW'(r_coef_tol));

    always_comb begin
        if (w_mag_b > CW'(r_coef_tol))      w_lin_out = qrs_pkg::OUT_LINEAR;
        else if (w_mag_c <= CW'(r_coef_tol)) w_lin_out = qrs_pkg::OUT_INFINITE;
        else                                 w_lin_out = qrs_pkg::OUT_NONE;
    end

    logic                 r1_valid;
    qrs_pkg::t_coefs      r1_coef;
    logic signed [DW-1:0] r1_bb, r1_ac;
    logic                 r1_lin;
    qrs_pkg::t_outcome    r1_lin_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_valid <= 1'b0;
        else          r1_valid <= w_acc;
        r1_coef    <= i_coef;
        r1_bb      <= i_coef.coef_b * i_coef.coef_b;
        r1_ac      <= i_coef.coef_a * i_coef.coef_c;
        r1_lin     <= w_lin;
        r1_lin_out <= w_lin_out;
    end

    // ---- stage 2: discriminant, clipped to its range
    logic signed [DW+2:0] w_dfull;
    logic                 w_dsat;
    logic signed [DW-1:0] w_dclip;

    assign w_dfull = (DW+3)'(r1_bb) - {r1_ac[DW-1], r1_ac, 2'b00};
    assign w_dsat  = (w_dfull[DW+2:DW-1] != '0) && (w_dfull[DW+2:DW-1] != '1);
    assign w_dclip = !w_dsat ? w_dfull[DW-1:0]
                   : (w_dfull[DW+2] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}});

    logic                 r2_valid;
    qrs_pkg::t_coefs      r2_coef;
    logic signed [DW-1:0] r2_d;
    logic                 r2_sat;
    logic                 r2_lin;
    qrs_pkg::t_outcome    r2_lin_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_valid <= 1'b0;
        else          r2_valid <= r1_valid;
        r2_coef    <= r1_coef;
        r2_d       <= w_dclip;
        r2_sat     <= w_dsat;
        r2_lin     <= r1_lin;
        r2_lin_out <= r1_lin_out;
    end

    // ---- classification, then the square root row
    logic signed [DW-1:0] w_tol;
    qrs_pkg::t_sq_meta    w_sq_in;
    logic [DW-1:0]        w_rad0;

    assign w_tol = DW'(r_disc_tol);

    always_comb begin
        w_sq_in.valid = r2_valid;
        w_sq_in.a     = r2_coef.coef_a;
        w_sq_in.b     = r2_coef.coef_b;
        w_sq_in.c     = r2_coef.coef_c;
        w_sq_in.sat   = r2_lin ? 1'b0 : r2_sat;
        if (r2_lin)               w_sq_in.outcome = r2_lin_out;
        else if (r2_d < -w_tol)   w_sq_in.outcome = qrs_pkg::OUT_NONE;
        else if (r2_d <= w_tol)   w_sq_in.outcome = qrs_pkg::OUT_DOUBLE;
        else                      w_sq_in.outcome = qrs_pkg::OUT_TWO;
    end

    assign w_rad0 = (w_sq_in.outcome == qrs_pkg::OUT_TWO) ? r2_d : '0;

    logic [DW-1:0] w_rad  [qrs_pkg::SqSteps+1];
    logic [RW:0]   w_srem [qrs_pkg::SqSteps+1];
    logic [RW-1:0] w_root [qrs_pkg::SqSteps+1];
    qrs_pkg::t_sq_meta r_sq_meta [qrs_pkg::SqSteps];

    assign w_rad[0]  = w_rad0;
    assign w_srem[0] = '0;
    assign w_root[0] = '0;

    for (genvar k = 0; k < qrs_pkg::SqSteps; k++) begin : g_sq
        qrs_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_rad  (w_rad[k]),
            .i_rem  (w_srem[k]),
            .i_root (w_root[k]),
            .o_rad  (w_rad[k+1]),
            .o_rem  (w_srem[k+1]),
            .o_root (w_root[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < qrs_pkg::SqSteps; k++) r_sq_meta[k] <= '0;
        end else begin
            r_sq_meta[0] <= w_sq_in;
            for (int k = 1; k < qrs_pkg::SqSteps; k++) r_sq_meta[k] <= r_sq_meta[k-1];
        end
    end

    // ---- numerators and denominator, then the divider rows
    qrs_pkg::t_sq_meta    w_sm;
    logic signed [NW-1:0] w_nb, w_s, w_num1, w_num2, w_den;
    qrs_pkg::t_div_meta   w_dm;
    logic [NW-1:0]        w_mn1, w_mn2, w_md;

    assign w_sm = r_sq_meta[qrs_pkg::SqSteps-1];
    assign w_nb = -NW'(w_sm.b);
    assign w_s  = NW'(w_root[qrs_pkg::SqSteps]);

    always_comb begin
        if (w_sm.outcome == qrs_pkg::OUT_LINEAR) begin
            w_num1 = -NW'(w_sm.c);
            w_den  = NW'(w_sm.b);
        end else begin
            w_num1 = w_nb - w_s;
            w_den  = {NW'(w_sm.a)} <<< 1;
        end
        w_num2 = w_nb + w_s;
    end

    assign w_mn1 = w_num1[NW-1] ? NW'(-w_num1) : w_num1;
    assign w_mn2 = w_num2[NW-1] ? NW'(-w_num2) : w_num2;
    assign w_md  = w_den[NW-1]  ? NW'(-w_den)  : w_den;

    always_comb begin
        w_dm.valid   = w_sm.valid;
        w_dm.outcome = w_sm.outcome;
        w_dm.sat     = w_sm.sat;
        w_dm.use1    = (w_sm.outcome == qrs_pkg::OUT_TWO) ||
                       (w_sm.outcome == qrs_pkg::OUT_DOUBLE) ||
                       (w_sm.outcome == qrs_pkg::OUT_LINEAR);
        w_dm.use2    = (w_sm.outcome == qrs_pkg::OUT_TWO);
        w_dm.neg1    = w_num1[NW-1] ^ w_den[NW-1];
        w_dm.neg2    = w_num2[NW-1] ^ w_den[NW-1];
    end

    logic [QW-1:0] w_n1 [qrs_pkg::DivSteps+1];
    logic [QW-1:0] w_n2 [qrs_pkg::DivSteps+1];
    logic [NW-1:0] w_d1 [qrs_pkg::DivSteps+1];
    logic [NW-1:0] w_d2 [qrs_pkg::DivSteps+1];
    logic [NW-1:0] w_r1 [qrs_pkg::DivSteps+1];
    logic [NW-1:0] w_r2 [qrs_pkg::DivSteps+1];
    logic [QW-1:0] w_q1 [qrs_pkg::DivSteps+1];
    logic [QW-1:0] w_q2 [qrs_pkg::DivSteps+1];
    qrs_pkg::t_div_meta r_dv_meta [qrs_pkg::DivSteps];

    assign w_n1[0] = {w_mn1, {FW{1'b0}}};
    assign w_n2[0] = {w_mn2, {FW{1'b0}}};
    assign w_d1[0] = w_md;
    assign w_d2[0] = w_md;
    assign w_r1[0] = '0;
    assign w_r2[0] = '0;
    assign w_q1[0] = '0;
    assign w_q2[0] = '0;

    for (genvar k = 0; k < qrs_pkg::DivSteps; k++) begin : g_div
        qrs_div_cell u_lo (
            .i_clk (i_clk),
            .i_num (w_n1[k]), .i_den (w_d1[k]), .i_rem (w_r1[k]), .i_quo (w_q1[k]),
            .o_num (w_n1[k+1]), .o_den (w_d1[k+1]), .o_rem (w_r1[k+1]), .o_quo (w_q1[k+1])
        );
        qrs_div_cell u_hi (
            .i_clk (i_clk),
            .i_num (w_n2[k]), .i_den (w_d2[k]), .i_rem (w_r2[k]), .i_quo (w_q2[k]),
            .o_num (w_n2[k+1]), .o_den (w_d2[k+1]), .o_rem (w_r2[k+1]), .o_quo (w_q2[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < qrs_pkg::DivSteps; k++) r_dv_meta[k] <= '0;
        end else begin
            r_dv_meta[0] <= w_dm;
            for (int k = 1; k < qrs_pkg::DivSteps; k++) r_dv_meta[k] <= r_dv_meta[k-1];
        end
    end

    // ---- sign, clip and order
    qrs_pkg::t_div_meta   w_fm;
    logic [QW-1:0]        w_qa, w_qb;
    logic                 w_ova, w_ovb;
    logic signed [CW-1:0] w_ra, w_rb, w_lo, w_hi;

    assign w_fm = r_dv_meta[qrs_pkg::DivSteps-1];
    assign w_qa = w_q1[qrs_pkg::DivSteps];
    assign w_qb = w_q2[qrs_pkg::DivSteps];

    // negative side reaches one step further than positive
    assign w_ova = w_fm.neg1 ? (w_qa > QW'({1'b1, {(CW-1){1'b0}}}))
                             : (w_qa[QW-1:CW-1] != '0);
    assign w_ovb = w_fm.neg2 ? (w_qb > QW'({1'b1, {(CW-1){1'b0}}}))
                             : (w_qb[QW-1:CW-1] != '0);

    always_comb begin
        if (!w_fm.use1)    w_ra = '0;
        else if (w_ova)    w_ra = w_fm.neg1 ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        else if (w_fm.neg1) w_ra = -w_qa[CW-1:0];
        else               w_ra = w_qa[CW-1:0];
        if (!w_fm.use2)    w_rb = '0;
        else if (w_ovb)    w_rb = w_fm.neg2 ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        else if (w_fm.neg2) w_rb = -w_qb[CW-1:0];
        else               w_rb = w_qb[CW-1:0];
        if (w_fm.use2 && (w_rb < w_ra)) begin
            w_lo = w_rb;
            w_hi = w_ra;
        end else begin
            w_lo = w_ra;
            w_hi = w_rb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= w_fm.valid;
        o_res.outcome     <= w_fm.outcome;
        o_res.root_first  <= w_lo;
        o_res.root_second <= w_hi;
        o_res.saturated   <= w_fm.sat || (w_fm.use1 && w_ova) || (w_fm.use2 && w_ovb);
    end

`ifndef SYNTHESIS
    a_roots_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_res.outcome == qrs_pkg::OUT_TWO) |-> o_res.root_first <= o_res.root_second)
        else $error("two roots out of order");
    a_no_root_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_res.outcome == qrs_pkg::OUT_NONE || o_res.outcome == qrs_pkg::OUT_INFINITE)
        |-> o_res.root_first == '0 && o_res.root_second == '0)
        else $error("root driven without a solution");
    a_single_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.outcome != qrs_pkg::OUT_TWO |-> o_res.root_second == '0)
        else $error("second root driven for a single result");
`endif
endmodule

### sim/quadratic_root_solver_checker.sv
// Result checker for the quadratic root solver: root prediction and beat comparison.
module quadratic_root_solver_checker
    import qrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_coefs      i_coef,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    input  t_result     i_res,
    output int          o_errors,
    output int          o_pending,
    output int          o_seen
);

    logic [15:0] coef_tol;
    logic [31:0] disc_tol;
    t_result     roots_due[$];

    // clip to a signed range of the given width
    function automatic logic signed [127:0] clip(input logic signed [127:0] v, input int w,
                                                 inout logic sat);
        logic signed [127:0] hi_lim;
        logic signed [127:0] lo_lim;
        hi_lim = (128'sd1 <<< (w - 1)) - 1;
        lo_lim = -(128'sd1 <<< (w - 1));
        if (v > hi_lim) begin
            sat = 1'b1;
            return hi_lim;
        end
        if (v < lo_lim) begin
            sat = 1'b1;
            return lo_lim;
        end
        return v;
    endfunction

    function automatic logic signed [127:0] div_root(input logic signed [127:0] num,
                                                     input logic signed [127:0] den,
                                                     inout logic sat);
        logic [127:0] un;
        logic [127:0] ud;
        logic signed [127:0] q;
        un = (num < 0) ? -num : num;
        ud = (den < 0) ? -den : den;
        q = $signed((un << FracW) / ud);
        if ((num < 0) != (den < 0)) q = -q;
        return clip(q, CoefW, sat);
    endfunction

    function automatic logic [127:0] floor_sqrt(input logic [127:0] v);
        logic [127:0] r;
        logic [127:0] t;
        r = 0;
        for (int k = 63; k >= 0; k--) begin
            t = r | (128'd1 << k);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic t_result solve_roots(input t_coefs c);
        t_result r;
        logic signed [127:0] a, b, cc, d, tol, r1, r2, s, tmp;
        logic sat;
        a = c.coef_a;
        b = c.coef_b;
        cc = c.coef_c;
        sat = 1'b0;
        r1 = 0;
        r2 = 0;
        tol = {96'd0, disc_tol};
        if ((a < 0 ? -a : a) <= coef_tol) begin
            if ((b < 0 ? -b : b) <= coef_tol)
                r.outcome = ((cc < 0 ? -cc : cc) <= coef_tol) ? OUT_INFINITE : OUT_NONE;
            else begin
                r.outcome = OUT_LINEAR;
                r1 = div_root(-cc, b, sat);
            end
        end else begin
            d = clip(b * b - 4 * a * cc, DiscW, sat);
            if (d < -tol) r.outcome = OUT_NONE;
            else if (d <= tol) begin
                r.outcome = OUT_DOUBLE;
                r1 = div_root(-b, 2 * a, sat);
            end else begin
                r.outcome = OUT_TWO;
                s = $signed(floor_sqrt(d));
                r1 = div_root(-b - s, 2 * a, sat);
                r2 = div_root(-b + s, 2 * a, sat);
                if (r2 < r1) begin
                    tmp = r1;
                    r1 = r2;
                    r2 = tmp;
                end
            end
        end
        r.root_first = r1[CoefW-1:0];
        r.root_second = r2[CoefW-1:0];
        r.saturated = sat;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s: got %0h, want %0h at %0t", what, got, want, $time);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            coef_tol <= '0;
            disc_tol <= '0;
            roots_due.delete();
            o_errors = 0;
            o_seen = 0;
        end else begin
            if (i_valid) begin
                o_seen++;
                if (roots_due.size() == 0)
                    report_mismatch("unexpected beat", 64'(i_res.root_first), 64'd0);
                else begin
                    want = roots_due.pop_front();
                    if (i_res.outcome !== want.outcome)
                        report_mismatch("outcome", 64'(i_res.outcome), 64'(want.outcome));
                    if (i_res.root_first !== want.root_first)
                        report_mismatch("root_first", 64'(i_res.root_first),
                                        64'(want.root_first));
                    if (i_res.root_second !== want.root_second)
                        report_mismatch("root_second", 64'(i_res.root_second),
                                        64'(want.root_second));
                    if (i_res.saturated !== want.saturated)
                        report_mismatch("saturated", 64'(i_res.saturated),
                                        64'(want.saturated));
                end
            end
            if (i_start && !i_busy) roots_due.push_back(solve_roots(i_coef));
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_COEF_TOL) coef_tol <= i_cfg_data[15:0];
                else disc_tol <= i_cfg_data;
            end
        end
        o_pending = roots_due.size();
    end

endmodule

### sim/quadratic_root_solver_top_tb.sv
// Testbench top for the quadratic root solver: stimulus, register phases and verdict.
module quadratic_root_solver_top_tb;
    import qrs_pkg::*;

    localparam int Drain = 120;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_coefs      i_coef;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        o_valid;
    t_result     o_res;
    int          errors;
    int          pending;
    int          seen;
    int          sent;

    quadratic_root_solver_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_coef(i_coef),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_res(o_res)
    );

    quadratic_root_solver_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy), .i_coef(i_coef),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(o_valid), .i_res(o_res), .o_errors(errors), .o_pending(pending),
        .o_seen(seen)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $signed($urandom_range(0, 8192)) - 4096;
            2: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
            3: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            4: return $signed($urandom_range(0, 6)) * 32'sh10000 - 32'sh30000;
            default: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom)};
        endcase
    endfunction

    // one beat, after a random gap; start stays high across back-to-back beats
    task automatic send_coefs(input logic [31:0] a, input logic [31:0] b,
                              input logic [31:0] c, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_coef <= '{coef_a: a, coef_b: b, coef_c: c};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sent++;
    endtask

    task automatic drain_all();
        int n;
        n = 0;
        start <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        while (n < Drain) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    // both tolerance registers, one beat each
    task automatic write_regs(input logic [31:0] coef_data, input logic [31:0] disc_data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_COEF_TOL;
        i_cfg_data <= coef_data;
        @(posedge i_clk);
        i_cfg_idx <= CFG_DISC_TOL;
        i_cfg_data <= disc_data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_coef = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_COEF_TOL;
        i_cfg_data = '0;
        sent = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes and each outcome with zero tolerances
        send_coefs(0, 0, 0, 0);
        send_coefs(0, 0, 32'h10000, 0);
        send_coefs(0, 32'h20000, 32'hfffc0000, 0);
        send_coefs(0, 1, 32'h7fffffff, 0);
        send_coefs(0, 32'h80000000, 32'h80000000, 0);
        send_coefs(32'h10000, 32'hfffd0000, 32'h20000, 0);
        send_coefs(32'h10000, 32'h20000, 32'h10000, 0);
        send_coefs(32'h10000, 0, 32'h10000, 0);
        send_coefs(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0);
        send_coefs(32'h80000000, 32'h80000000, 32'h7fffffff, 0);
        send_coefs(1, 32'h80000000, 32'h80000000, 0);
        send_coefs(32'hffffffff, 32'h7fffffff, 32'h80000000, 0);
        send_coefs(1, 32'h7fffffff, 0, 0);
        send_coefs(32'h80000000, 0, 32'h80000000, 0);
        send_coefs(32'hffffffff, 0, 32'hffffffff, 0);
        drain_all();

        // tolerance edges
        write_regs(32'hffff, 32'hffffffff);
        send_coefs(32'hffff, 32'hffff0001, 32'h1, 0);
        send_coefs(32'h10000, 32'hffff, 32'h10000, 0);
        send_coefs(32'h10000, 32'h20000, 32'h10000, 0);
        send_coefs(32'h10000, 32'h20001, 32'h10000, 0);
        send_coefs(32'h10000, 32'h1ffff, 32'h10000, 0);
        send_coefs(0, 0, 32'hffff0001, 0);
        drain_all();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_regs(0, 0);
                5: write_regs(32'hffff, 32'hffffffff);
                default: write_regs($urandom_range(0, 65535), $urandom);
            endcase
            for (int k = 0; k < 272; k++)
                send_coefs(rand_coef(), rand_coef(), rand_coef(), (k % 90) < 60);
            // the sender holds off until every result is back
            drain_all();
        end

        $display("sent %0d coefficient sets over eight tolerance settings, %0d results seen",
                 sent, seen);
        if (errors == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

    initial begin
        #20000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### quadratic_root_solver_top.f
hdl/qrs_pkg.sv
hdl/qrs_sqrt_cell.sv
hdl/qrs_div_cell.sv
hdl/quadratic_root_solver_top.sv
sim/quadratic_root_solver_checker.sv
sim/quadratic_root_solver_top_tb.sv
